// ----- src/skl_pkg.sv -----
// shared types and constants of the sorted key list
package skl_pkg;

   localparam int LIST_DEPTH_DEFAULT = 32;
   localparam int KEY_W = 32;
   localparam int PAYLOAD_W = 64;
   localparam int STATUS_W = 3;
   localparam int COUNT_OUT_W = 6;

   typedef enum logic [1:0] {
      CMD_INSERT = 2'd0,
      CMD_DELETE = 2'd1,
      CMD_DUMP   = 2'd2
   } command_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_INSERTED = 3'd0,
      ST_DELETED  = 3'd1,
      ST_FULL     = 3'd2,
      ST_MISSING  = 3'd3,
      ST_LISTED   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_EXEC,
      S_DUMP
   } state_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic latch_req;
      logic exec;
      logic dump_step;
   } dp_ctrl_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic        out_free;
      logic [1:0]  cmd;
      logic        fill_zero;
      logic        dump_last;
   } dp_status_type;

endpackage

// ----- src/skl_if.sv -----
// request and response channel interfaces of the sorted key list
interface skl_req_if;
   logic                valid;
   logic                ready;
   logic [1:0]          command;
   logic signed [31:0]  key;
   logic [63:0]         payload;

   modport source (output valid, output command, output key, output payload, input ready);
   modport sink   (input valid, input command, input key, input payload, output ready);
endinterface

interface skl_rsp_if;
   logic                valid;
   logic                ready;
   logic [2:0]          status;
   logic signed [31:0]  out_key;
   logic [63:0]         out_payload;
   logic [5:0]          entry_count;
   logic                last;

   modport source (output valid, output status, output out_key, output out_payload,
                   output entry_count, output last, input ready);
   modport sink   (input valid, input status, input out_key, input out_payload,
                   input entry_count, input last, output ready);
endinterface

// ----- src/skl_ctrl.sv -----
// controller state machine of the sorted key list
module skl_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  skl_pkg::dp_status_type dp_status,
   output skl_pkg::dp_ctrl_type   dp_ctrl
);
   import skl_pkg::*;

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      dp_ctrl   = '0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready = dp_status.out_free;
            if (req_valid && dp_status.out_free) begin
               dp_ctrl.latch_req = 1'b1;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            case (dp_status.cmd) inside
               CMD_INSERT, CMD_DELETE: begin
                  if (dp_status.out_free) begin
                     dp_ctrl.exec = 1'b1;
                     state_in = S_IDLE;
                  end
               end
               CMD_DUMP: begin
                  state_in = dp_status.fill_zero ? S_IDLE : S_DUMP;
               end
               default: begin
                  state_in = S_IDLE;
               end
            endcase
         end
         S_DUMP: begin
            if (dp_status.out_free) begin
               dp_ctrl.dump_step = 1'b1;
               if (dp_status.dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule

// ----- src/skl_datapath.sv -----
// cell chain, fill counter and result register of the sorted key list
module skl_datapath #(
   parameter int LIST_DEPTH = skl_pkg::LIST_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  skl_pkg::dp_ctrl_type   dp_ctrl,
   output skl_pkg::dp_status_type dp_status,
   input  logic [1:0]             req_command,
   input  logic signed [31:0]     req_key,
   input  logic [63:0]            req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [2:0]             rsp_status,
   output logic signed [31:0]     rsp_out_key,
   output logic [63:0]            rsp_out_payload,
   output logic [5:0]             rsp_entry_count,
   output logic                   rsp_last
);
   import skl_pkg::*;

   localparam int CntW = $clog2(LIST_DEPTH + 1);
   localparam int IdxW = $clog2(LIST_DEPTH);

   // latched request
   logic [1:0]               cmd_ff;
   logic signed [KEY_W-1:0]  key_ff;
   logic [PAYLOAD_W-1:0]     pay_ff;

   // entry cells
   logic signed [KEY_W-1:0]  cell_key_ff [LIST_DEPTH];
   logic signed [KEY_W-1:0]  cell_key_in [LIST_DEPTH];
   logic [PAYLOAD_W-1:0]     cell_pay_ff [LIST_DEPTH];
   logic [PAYLOAD_W-1:0]     cell_pay_in [LIST_DEPTH];

   logic [CntW-1:0] fill_ff, fill_in;
   logic [IdxW-1:0] dump_idx_ff, dump_idx_in;

   // result register
   logic                   out_valid_ff, out_valid_in;
   logic [STATUS_W-1:0]    out_status_ff, out_status_in;
   logic signed [KEY_W-1:0] out_key_ff, out_key_in;
   logic [PAYLOAD_W-1:0]   out_pay_ff, out_pay_in;
   logic [CntW-1:0]        out_count_ff, out_count_in;
   logic                   out_last_ff, out_last_in;

   logic [LIST_DEPTH-1:0] cell_lt;
   logic [LIST_DEPTH-1:0] cell_match;
   logic [LIST_DEPTH-1:0] cell_tail;
   logic                  is_full, found, out_free, dump_last;
   logic                  do_insert, do_delete, do_rotate;

   // per-cell compares against the request key
   genvar g;
   generate
      for (g = 0; g < LIST_DEPTH; g++) begin : g_cmp
         logic valid_c;
         assign valid_c       = (CntW'(g) < fill_ff);
         assign cell_lt[g]    = valid_c && (cell_key_ff[g] < key_ff);
         assign cell_match[g] = valid_c && (cell_key_ff[g] == key_ff);
         assign cell_tail[g]  = (CntW'(g) == fill_ff - CntW'(1));
      end
   endgenerate

   assign is_full   = (fill_ff >= CntW'(LIST_DEPTH));
   assign found     = |cell_match;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign dump_last = (CntW'(dump_idx_ff) == fill_ff - CntW'(1));

   assign do_insert = dp_ctrl.exec && (cmd_ff == CMD_INSERT) && !is_full;
   assign do_delete = dp_ctrl.exec && (cmd_ff == CMD_DELETE) && found;
   assign do_rotate = dp_ctrl.dump_step;

   // next value of each cell: insert opens a gap, delete closes one, dump rotates
   generate
      for (g = 0; g < LIST_DEPTH; g++) begin : g_cell
         always_comb begin
            cell_key_in[g] = cell_key_ff[g];
            cell_pay_in[g] = cell_pay_ff[g];
            if (do_insert) begin
               if (!cell_lt[g]) begin
                  if (g == 0) begin
                     cell_key_in[g] = key_ff;
                     cell_pay_in[g] = pay_ff;
                  end else if (cell_lt[(g == 0) ? 0 : g-1]) begin
                     cell_key_in[g] = key_ff;
                     cell_pay_in[g] = pay_ff;
                  end else begin
                     cell_key_in[g] = cell_key_ff[(g == 0) ? 0 : g-1];
                     cell_pay_in[g] = cell_pay_ff[(g == 0) ? 0 : g-1];
                  end
               end
            end else if (do_delete) begin
               // equal keys sit together, so every cell from the first match on shifts
               if (!cell_lt[g] && (g < LIST_DEPTH - 1)) begin
                  cell_key_in[g] = cell_key_ff[(g < LIST_DEPTH - 1) ? g+1 : g];
                  cell_pay_in[g] = cell_pay_ff[(g < LIST_DEPTH - 1) ? g+1 : g];
               end
            end else if (do_rotate) begin
               if (cell_tail[g]) begin
                  cell_key_in[g] = cell_key_ff[0];
                  cell_pay_in[g] = cell_pay_ff[0];
               end else if (g < LIST_DEPTH - 1) begin
                  cell_key_in[g] = cell_key_ff[(g < LIST_DEPTH - 1) ? g+1 : g];
                  cell_pay_in[g] = cell_pay_ff[(g < LIST_DEPTH - 1) ? g+1 : g];
               end
            end
         end

         always_ff @(posedge clock) begin
            cell_key_ff[g] <= cell_key_in[g];
            cell_pay_ff[g] <= cell_pay_in[g];
         end
      end
   endgenerate

   // fill counter, dump index and result register
   always_comb begin
      fill_in       = fill_ff;
      dump_idx_in   = dump_idx_ff;
      out_valid_in  = out_valid_ff && !rsp_ready;
      out_status_in = out_status_ff;
      out_key_in    = out_key_ff;
      out_pay_in    = out_pay_ff;
      out_count_in  = out_count_ff;
      out_last_in   = out_last_ff;
      if (dp_ctrl.latch_req) begin
         dump_idx_in = '0;
      end
      if (do_insert) begin
         fill_in = fill_ff + CntW'(1);
      end else if (do_delete) begin
         fill_in = fill_ff - CntW'(1);
      end
      if (dp_ctrl.exec) begin
         out_valid_in = 1'b1;
         out_key_in   = key_ff;
         out_pay_in   = '0;
         out_last_in  = 1'b1;
         out_count_in = fill_in;
         if (cmd_ff == CMD_INSERT) begin
            out_status_in = is_full ? ST_FULL : ST_INSERTED;
         end else begin
            out_status_in = found ? ST_DELETED : ST_MISSING;
         end
      end
      if (dp_ctrl.dump_step) begin
         out_valid_in  = 1'b1;
         out_status_in = ST_LISTED;
         out_key_in    = cell_key_ff[0];
         out_pay_in    = cell_pay_ff[0];
         out_count_in  = fill_ff;
         out_last_in   = dump_last;
         dump_idx_in   = dump_idx_ff + IdxW'(1);
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         out_valid_ff <= 1'b0;
         dump_idx_ff  <= '0;
      end else begin
         fill_ff      <= fill_in;
         out_valid_ff <= out_valid_in;
         dump_idx_ff  <= dump_idx_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (dp_ctrl.latch_req) begin
         cmd_ff <= req_command;
         key_ff <= req_key;
         pay_ff <= req_payload;
      end
      out_status_ff <= out_status_in;
      out_key_ff    <= out_key_in;
      out_pay_ff    <= out_pay_in;
      out_count_ff  <= out_count_in;
      out_last_ff   <= out_last_in;
   end

   assign dp_status.out_free  = out_free;
   assign dp_status.cmd       = cmd_ff;
   assign dp_status.fill_zero = (fill_ff == '0);
   assign dp_status.dump_last = dump_last;

   assign rsp_valid       = out_valid_ff;
   assign rsp_status      = out_status_ff;
   assign rsp_out_key     = out_key_ff;
   assign rsp_out_payload = out_pay_ff;
   assign rsp_entry_count = COUNT_OUT_W'(out_count_ff);
   assign rsp_last        = out_last_ff;

endmodule

// ----- src/sorted_key_list.sv -----
// sorted key list: an insert or delete result reaches the output register through the request
// latch and one pass through the cell chain, held back while the output register is busy; a
// dump passes the request latch and the empty check, then gives one result per cycle while
// the output register is free, as the chain rotates past cell 0; one transaction in work at
// a time; a request is taken only while the output register is free
// synchronous active-high reset empties the list and drops any pending result; cells not cleared
module sorted_key_list #(
   parameter int LIST_DEPTH = skl_pkg::LIST_DEPTH_DEFAULT
) (
   input logic     clock,
   input logic     reset,
   skl_req_if.sink req,
   skl_rsp_if.source rsp
);
   import skl_pkg::*;

   dp_ctrl_type   dp_ctrl;
   dp_status_type dp_status;

   // controller
   skl_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req.valid),
      .req_ready (req.ready),
      .dp_status (dp_status),
      .dp_ctrl   (dp_ctrl)
   );

   // datapath
   skl_datapath #(
      .LIST_DEPTH (LIST_DEPTH)
   ) u_datapath (
      .clock           (clock),
      .reset           (reset),
      .dp_ctrl         (dp_ctrl),
      .dp_status       (dp_status),
      .req_command     (req.command),
      .req_key         (req.key),
      .req_payload     (req.payload),
      .rsp_valid       (rsp.valid),
      .rsp_ready       (rsp.ready),
      .rsp_status      (rsp.status),
      .rsp_out_key     (rsp.out_key),
      .rsp_out_payload (rsp.out_payload),
      .rsp_entry_count (rsp.entry_count),
      .rsp_last        (rsp.last)
   );

endmodule

// ----- tb/sv/skl_list_checker.sv -----
`timescale 1ns / 1ps
// checker for the sorted key list: tracks the list contents, predicts responses and compares them
module skl_list_checker #(
   parameter int LIST_DEPTH = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic signed [31:0] req_key,
   input  logic [63:0]        req_payload,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic [2:0]         rsp_status,
   input  logic signed [31:0] rsp_out_key,
   input  logic [63:0]        rsp_out_payload,
   input  logic [5:0]         rsp_entry_count,
   input  logic               rsp_last,
   output int                 fail_count,
   output int                 responses_awaited
);
   import skl_pkg::*;

   typedef struct packed {
      status_type         status;
      logic signed [31:0] out_key;
      logic [63:0]        out_payload;
      logic [5:0]         entry_count;
      logic               last;
   } list_response_type;

   // shadow copy of the list, kept in ascending signed key order
   logic signed [31:0] held_keys [LIST_DEPTH];
   logic [63:0]        held_payloads [LIST_DEPTH];
   int                 held_count;

   list_response_type  awaited_responses[$];

   task automatic report_mismatch(input string field, input logic [63:0] got,
                                  input logic [63:0] want);
      if (fail_count < 200)
         $display("%0t ns: %s mismatch, got %h, wanted %h", $time, field, got, want);
      fail_count++;
   endtask

   task automatic queue_response(input status_type st, input logic signed [31:0] k,
                                 input logic [63:0] p, input logic lst);
      list_response_type r;
      r.status      = st;
      r.out_key     = k;
      r.out_payload = p;
      r.entry_count = held_count[5:0];
      r.last        = lst;
      awaited_responses.push_back(r);
   endtask

   // update the shadow list for one accepted request and queue what it causes
   task automatic apply_list_command(input logic [1:0] cmd, input logic signed [31:0] k,
                                     input logic [63:0] p);
      int pos;
      int i;
      case (cmd)
         CMD_INSERT: begin
            if (held_count >= LIST_DEPTH) begin
               queue_response(ST_FULL, k, '0, 1'b1);
            end else begin
               // lands after smaller keys and ahead of equal ones
               pos = 0;
               while (pos < held_count && held_keys[pos] < k)
                  pos++;
               for (i = held_count; i > pos; i--) begin
                  held_keys[i]     = held_keys[i-1];
                  held_payloads[i] = held_payloads[i-1];
               end
               held_keys[pos]     = k;
               held_payloads[pos] = p;
               held_count++;
               queue_response(ST_INSERTED, k, '0, 1'b1);
            end
         end
         CMD_DELETE: begin
            pos = 0;
            while (pos < held_count && held_keys[pos] != k)
               pos++;
            if (pos >= held_count) begin
               queue_response(ST_MISSING, k, '0, 1'b1);
            end else begin
               for (i = pos; i + 1 < held_count; i++) begin
                  held_keys[i]     = held_keys[i+1];
                  held_payloads[i] = held_payloads[i+1];
               end
               held_count--;
               queue_response(ST_DELETED, k, '0, 1'b1);
            end
         end
         CMD_DUMP: begin
            for (i = 0; i < held_count; i++)
               queue_response(ST_LISTED, held_keys[i], held_payloads[i],
                              (i + 1 == held_count));
         end
         default: begin
            // unused code: no change and no response
         end
      endcase
   endtask

   // compare one response transaction with the oldest prediction
   task automatic check_response();
      list_response_type want;
      if (awaited_responses.size() == 0) begin
         report_mismatch("unexpected response, status", rsp_status, '0);
         return;
      end
      want = awaited_responses.pop_front();
      if (rsp_status !== want.status)
         report_mismatch("status", rsp_status, want.status);
      if (rsp_out_key !== want.out_key)
         report_mismatch("out_key", rsp_out_key, want.out_key);
      if (rsp_out_payload !== want.out_payload)
         report_mismatch("out_payload", rsp_out_payload, want.out_payload);
      if (rsp_entry_count !== want.entry_count)
         report_mismatch("entry_count", rsp_entry_count, want.entry_count);
      if (rsp_last !== want.last)
         report_mismatch("last", rsp_last, want.last);
   endtask

   // watch both channels at the rising edge
   always @(posedge clock) begin
      if (reset) begin
         held_count = 0;
         awaited_responses.delete();
      end else begin
         if (req_valid && req_ready)
            apply_list_command(req_command, req_key, req_payload);
         if (rsp_valid && rsp_ready)
            check_response();
      end
      responses_awaited = awaited_responses.size();
   end

endmodule

// ----- tb/sv/tb_sorted_key_list.sv -----
`timescale 1ns / 1ps
// top of the sorted key list testbench: clock, reset, request and response stimulus, verdict
module tb_sorted_key_list;
   import skl_pkg::*;

   localparam int LIST_DEPTH    = 32;
   localparam int RANDOM_ITEMS  = 260;
   localparam int CALM_ITEMS    = 40;
   localparam int DRAIN_CYCLES  = 60;
   localparam int CYCLE_LIMIT   = 1_000_000;

   localparam logic [1:0]         CMD_UNUSED = 2'd3;
   localparam logic signed [31:0] KEY_MIN    = 32'sh8000_0000;
   localparam logic signed [31:0] KEY_MAX    = 32'sh7fff_ffff;

   typedef enum {SEG_GROW, SEG_SHRINK, SEG_MIXED} segment_kind_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   bit   calm  = 1'b0;
   int   cycle_count = 0;
   int   fail_count;
   int   responses_awaited;

   // keys believed held, only for steering deletes towards hits
   logic signed [31:0] stored_keys[$];

   skl_req_if req_ch ();
   skl_rsp_if rsp_ch ();

   sorted_key_list #(
      .LIST_DEPTH(LIST_DEPTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req(req_ch),
      .rsp(rsp_ch)
   );

   skl_list_checker #(
      .LIST_DEPTH(LIST_DEPTH)
   ) list_check (
      .clock(clock),
      .reset(reset),
      .req_valid(req_ch.valid),
      .req_ready(req_ch.ready),
      .req_command(req_ch.command),
      .req_key(req_ch.key),
      .req_payload(req_ch.payload),
      .rsp_valid(rsp_ch.valid),
      .rsp_ready(rsp_ch.ready),
      .rsp_status(rsp_ch.status),
      .rsp_out_key(rsp_ch.out_key),
      .rsp_out_payload(rsp_ch.out_payload),
      .rsp_entry_count(rsp_ch.entry_count),
      .rsp_last(rsp_ch.last),
      .fail_count(fail_count),
      .responses_awaited(responses_awaited)
   );

   // 20 ns clock
   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("CHECKS FAILED");
         $finish;
      end
   end

   // response side: random stall bursts, always ready once calm
   initial begin
      rsp_ch.ready = 1'b0;
      @(negedge clock);
      forever begin
         if (calm || $urandom_range(0, 2) != 0) begin
            rsp_ch.ready = 1'b1;
            repeat ($urandom_range(1, 30)) @(negedge clock);
         end else begin
            rsp_ch.ready = 1'b0;
            repeat ($urandom_range(1, 19)) @(negedge clock);
         end
      end
   end

   function automatic logic signed [31:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2, 3: pick_key = $urandom();
         4, 5, 6:    pick_key = $signed($urandom_range(0, 15)) - 8;
         7:          pick_key = KEY_MIN;
         8:          pick_key = KEY_MAX;
         default:    pick_key = $urandom_range(0, 1) ? KEY_MIN + $urandom_range(0, 3)
                                                     : KEY_MAX - $urandom_range(0, 3);
      endcase
   endfunction

   // present one request at the falling edge and hold it until accepted
   task automatic send_request(input logic [1:0] cmd, input logic signed [31:0] k,
                               input logic [63:0] p);
      int  idx;
      bit  found;
      if (!calm && $urandom_range(0, 4) == 0) begin
         req_ch.valid = 1'b0;
         repeat ($urandom_range(1, 19)) @(negedge clock);
      end
      req_ch.valid   = 1'b1;
      req_ch.command = cmd;
      req_ch.key     = k;
      req_ch.payload = p;
      @(posedge clock);
      while (!req_ch.ready)
         @(posedge clock);
      if (cmd == CMD_INSERT && stored_keys.size() < LIST_DEPTH) begin
         stored_keys.push_back(k);
      end else if (cmd == CMD_DELETE) begin
         found = 1'b0;
         for (idx = 0; idx < stored_keys.size() && !found; idx++) begin
            if (stored_keys[idx] == k) begin
               stored_keys.delete(idx);
               found = 1'b1;
            end
         end
      end
      @(negedge clock);
   endtask

   // main stimulus
   initial begin
      segment_kind_type   seg_kind;
      int                 seg_index;
      int                 random_sent;
      int                 steps;
      int                 overfull;
      int                 roll;
      int                 ins_pct;
      int                 del_pct;
      int                 dump_pct;
      logic [1:0]         cmd;
      logic signed [31:0] k;
      bit                 was_full;

      req_ch.valid   = 1'b0;
      req_ch.command = CMD_INSERT;
      req_ch.key     = '0;
      req_ch.payload = '0;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: empty list cases, extremes, equal keys, unused code
      send_request(CMD_DUMP,   0, '0);
      send_request(CMD_UNUSED, 5, 64'h1234);
      send_request(CMD_DELETE, 0, '0);
      send_request(CMD_INSERT, KEY_MIN, '1);
      send_request(CMD_INSERT, KEY_MAX, '0);
      send_request(CMD_INSERT, 0, 64'ha5a5_a5a5_a5a5_a5a5);
      send_request(CMD_INSERT, -1, 64'h5a5a_5a5a_5a5a_5a5a);
      send_request(CMD_INSERT, 0, 64'h0123_4567_89ab_cdef);
      send_request(CMD_INSERT, 1, 64'hfedc_ba98_7654_3210);
      send_request(CMD_INSERT, KEY_MIN, 64'h8000_0000_0000_0001);
      send_request(CMD_INSERT, KEY_MAX, 64'h7fff_ffff_ffff_fffe);
      send_request(CMD_DUMP,   0, '0);
      send_request(CMD_DELETE, 0, '0);
      send_request(CMD_DELETE, KEY_MAX, '0);
      send_request(CMD_DELETE, 12345, '0);
      send_request(CMD_DELETE, KEY_MIN, '0);
      send_request(CMD_DUMP,   0, '0);
      send_request(CMD_UNUSED, '1, '1);
      send_request(CMD_INSERT, 7, {$urandom(), $urandom()});
      send_request(CMD_DUMP,   0, '0);

      // random: fill to overflow, drain to empty, then mixed segments
      random_sent = 0;
      seg_index   = 0;
      while (random_sent < RANDOM_ITEMS) begin
         if (seg_index == 0)
            seg_kind = SEG_GROW;
         else if (seg_index == 1)
            seg_kind = SEG_SHRINK;
         else
            seg_kind = segment_kind_type'($urandom_range(0, 2));
         case (seg_kind)
            SEG_GROW:   begin ins_pct = 80; del_pct = 10; dump_pct = 8;  end
            SEG_SHRINK: begin ins_pct = 12; del_pct = 78; dump_pct = 8;  end
            default:    begin ins_pct = 45; del_pct = 40; dump_pct = 13; end
         endcase
         steps    = 0;
         overfull = 0;
         do begin
            calm = (random_sent >= RANDOM_ITEMS - CALM_ITEMS);
            roll = $urandom_range(0, 99);
            if (roll < ins_pct)
               cmd = CMD_INSERT;
            else if (roll < ins_pct + del_pct)
               cmd = CMD_DELETE;
            else if (roll < ins_pct + del_pct + dump_pct)
               cmd = CMD_DUMP;
            else
               cmd = CMD_UNUSED;
            if (cmd == CMD_DELETE && stored_keys.size() > 0 && $urandom_range(0, 5) != 0)
               k = stored_keys[$urandom_range(0, stored_keys.size() - 1)];
            else
               k = pick_key();
            was_full = (stored_keys.size() >= LIST_DEPTH);
            send_request(cmd, k, {$urandom(), $urandom()});
            if (cmd != CMD_UNUSED)
               random_sent++;
            if (cmd == CMD_INSERT && was_full)
               overfull++;
            steps++;
         end while (random_sent < RANDOM_ITEMS && steps < 80 &&
                    !(seg_kind == SEG_GROW && overfull >= 2) &&
                    !(seg_kind == SEG_SHRINK && stored_keys.size() == 0 && steps > 2) &&
                    !(seg_kind == SEG_MIXED && steps >= 30));
         seg_index++;
      end
      req_ch.valid = 1'b0;

      // wait out every awaited response, then a quiet tail
      while (responses_awaited != 0)
         @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
      if (fail_count == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

endmodule
